### rtl/dfi_pkg.sv
`timescale 1ns / 1ps
package dfi_pkg;

	localparam int ORDER          = 3;
	localparam int HIST_DEPTH     = 3;
	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_WIDTH     = 18;
	localparam int COEF_FRAC_BITS = 14;
	localparam int NUM_REGS       = 2 * HIST_DEPTH + 2;
	localparam int CFG_ADDR_WIDTH = $clog2(NUM_REGS);

	// full product, sum of every tap, and the word left after the fraction drop
	localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH   = PROD_WIDTH + $clog2(2 * ORDER + 2);
	localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

	typedef logic signed [SAMPLE_WIDTH-1:0]   sample_t;
	typedef logic signed [COEF_WIDTH-1:0]     coef_t;
	typedef logic [CFG_ADDR_WIDTH-1:0]        cfg_addr_t;
	typedef logic signed [PROD_WIDTH-1:0]     prod_t;
	typedef logic signed [ACC_WIDTH-1:0]      acc_t;
	typedef logic signed [SHIFT_WIDTH-1:0]    shifted_t;

	localparam coef_t    COEF_ONE   = coef_t'(1) <<< COEF_FRAC_BITS;
	localparam acc_t     ROUND_HALF = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
	localparam shifted_t SAMPLE_MAX = (shifted_t'(1) <<< (SAMPLE_WIDTH - 1)) - shifted_t'(1);
	localparam shifted_t SAMPLE_MIN = -(shifted_t'(1) <<< (SAMPLE_WIDTH - 1));

	typedef enum logic [CFG_ADDR_WIDTH-1:0] {
		REG_COEF_B0        = CFG_ADDR_WIDTH'(0),
		REG_COEF_B1        = CFG_ADDR_WIDTH'(1),
		REG_COEF_B2        = CFG_ADDR_WIDTH'(2),
		REG_COEF_B3        = CFG_ADDR_WIDTH'(3),
		REG_COEF_A1        = CFG_ADDR_WIDTH'(4),
		REG_COEF_A2        = CFG_ADDR_WIDTH'(5),
		REG_COEF_A3        = CFG_ADDR_WIDTH'(6),
		REG_RECURSIVE_MODE = CFG_ADDR_WIDTH'(7)
	} cfg_reg_t;

	// b[k] weighs x[n-k]; a[k] weighs y[n-k-1]
	typedef struct packed {
		coef_t [HIST_DEPTH:0]   b;
		coef_t [HIST_DEPTH-1:0] a;
		logic                   recursive;
	} coef_set_t;

	// newest entry at index 0
	typedef struct packed {
		sample_t [HIST_DEPTH-1:0] x;
		sample_t [HIST_DEPTH-1:0] y;
	} hist_set_t;

endpackage

### rtl/dfi_if.sv
`timescale 1ns / 1ps
interface dfi_sample_if;
	import dfi_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface dfi_result_if;
	import dfi_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface dfi_cfg_if;
	import dfi_pkg::*;

	logic      valid;
	logic      ready;
	cfg_addr_t addr;
	coef_t     data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

### rtl/dfi_coef_regs.sv
`timescale 1ns / 1ps
module dfi_coef_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  dfi_pkg::cfg_addr_t  wr_addr,
	input  dfi_pkg::coef_t      wr_data,
	output dfi_pkg::coef_set_t  coefs
);
	import dfi_pkg::*;

	coef_t [HIST_DEPTH:0]   b_q;
	coef_t [HIST_DEPTH-1:0] a_q;
	logic                   recursive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q         <= {{(HIST_DEPTH * COEF_WIDTH){1'b0}}, COEF_ONE};
			a_q         <= '0;
			recursive_q <= 1'b0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_addr))
				REG_COEF_B0:        b_q[0] <= wr_data;
				REG_COEF_B1:        b_q[1] <= wr_data;
				REG_COEF_B2:        b_q[2] <= wr_data;
				REG_COEF_B3:        b_q[3] <= wr_data;
				REG_COEF_A1:        a_q[0] <= wr_data;
				REG_COEF_A2:        a_q[1] <= wr_data;
				REG_COEF_A3:        a_q[2] <= wr_data;
				REG_RECURSIVE_MODE: recursive_q <= wr_data[0];
				default:            ;
			endcase
		end
	end

	assign coefs.b         = b_q;
	assign coefs.a         = a_q;
	assign coefs.recursive = recursive_q;

endmodule

### rtl/dfi_history.sv
`timescale 1ns / 1ps
module dfi_history (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  dfi_pkg::sample_t   x_new,
	input  dfi_pkg::sample_t   y_new,
	output dfi_pkg::hist_set_t hist
);
	import dfi_pkg::*;

	sample_t [HIST_DEPTH-1:0] x_hist_q;
	sample_t [HIST_DEPTH-1:0] y_hist_q;

	// advance both delay lines by one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_hist_q <= '0;
			y_hist_q <= '0;
		end else if (shift_en) begin
			for (int k = HIST_DEPTH - 1; k > 0; k--) begin
				x_hist_q[k] <= x_hist_q[k-1];
				y_hist_q[k] <= y_hist_q[k-1];
			end
			x_hist_q[0] <= x_new;
			y_hist_q[0] <= y_new;
		end
	end

	assign hist.x = x_hist_q;
	assign hist.y = y_hist_q;

endmodule

### rtl/dfi_mac.sv
`timescale 1ns / 1ps
module dfi_mac (
	input  dfi_pkg::sample_t   x,
	input  dfi_pkg::hist_set_t hist,
	input  dfi_pkg::coef_set_t coefs,
	output dfi_pkg::sample_t   y,
	output logic               clip
);
	import dfi_pkg::*;

	prod_t                  prod_x0;
	prod_t [ORDER-1:0]      prod_b;
	prod_t [ORDER-1:0]      prod_a;
	acc_t                   acc;
	acc_t                   acc_rnd;
	shifted_t               y_wide;

	// one multiplier per tap, all in parallel
	always_comb begin
		prod_x0 = $signed(coefs.b[0]) * $signed(x);
		for (int k = 0; k < ORDER; k++) begin
			prod_b[k] = $signed(coefs.b[k+1]) * $signed(hist.x[k]);
			prod_a[k] = $signed(coefs.a[k]) * $signed(hist.y[k]);
		end
	end

	// feedback terms only count in recursive mode
	always_comb begin
		acc = acc_t'(prod_x0);
		for (int k = 0; k < ORDER; k++) begin
			acc = acc + acc_t'(prod_b[k]);
			if (coefs.recursive) begin
				acc = acc - acc_t'(prod_a[k]);
			end
		end
	end

	// round half up, drop the fraction, then clamp to the sample range
	assign acc_rnd = acc + ROUND_HALF;
	assign y_wide  = shifted_t'(acc_rnd >>> COEF_FRAC_BITS);

	always_comb begin
		if (y_wide > SAMPLE_MAX) begin
			y    = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else if (y_wide < SAMPLE_MIN) begin
			y    = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else begin
			y    = y_wide[SAMPLE_WIDTH-1:0];
			clip = 1'b0;
		end
	end

endmodule

### rtl/iir_fir_direct_form_one_filter.sv
// Direct Form I filter of order three, FIR or IIR, on signed 16-bit samples.
// Channels: sample (sink) moves one input sample per transfer; result (source)
// moves one filtered sample and its clipped flag per transfer; cfg (sink)
// writes one coefficient or the mode bit per transfer, index as listed in the
// package enum. cfg is always ready; write it only while the filter is idle.
// A sample goes first into the input register and then into the result
// register, where its result is shown as valid. Throughput: one sample per
// cycle while result.ready stays high. The whole multiply-accumulate,
// rounding and saturation sits between the input register and the result
// register, because the saturated output feeds the next sample through the output delay line.
// Stall: when the receiver holds ready low, the result register holds; one
// more sample is still taken into the input register, then sample.ready
// drops until the result drains.
// Reset: both delay lines clear to zero, b0 returns to 1.0, all other
// coefficients to zero, FIR mode, and both pipeline stages empty.
`timescale 1ns / 1ps
module iir_fir_direct_form_one_filter (
	input  logic         clk,
	input  logic         arst_n,
	dfi_sample_if.sink   sample,
	dfi_result_if.source result,
	dfi_cfg_if.sink      cfg
);
	import dfi_pkg::*;

	coef_set_t coefs;
	hist_set_t hist;

	logic      valid_s1;
	sample_t   x_s1;
	logic      valid_s2;
	sample_t   y_s2;
	logic      clip_s2;

	sample_t   y_comb;
	logic      clip_comb;
	logic      advance;

	// configuration writes go straight into the coefficient registers, so never push back
	assign cfg.ready = 1'b1;

	dfi_coef_regs u_coef_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_addr (cfg.addr),
		.wr_data (cfg.data),
		.coefs   (coefs)
	);

	// move the sample in stage 1 into the result register when that is free
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// hold the input sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			x_s1 <= sample.sample_in;
		end
	end

	dfi_mac u_mac (
		.x     (x_s1),
		.hist  (hist),
		.coefs (coefs),
		.y     (y_comb),
		.clip  (clip_comb)
	);

	// the delay lines advance exactly once per sample, when it leaves stage 1
	dfi_history u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (advance),
		.x_new    (x_s1),
		.y_new    (y_comb),
		.hist     (hist)
	);

	// result register: fill on advance, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2    <= y_comb;
			clip_s2 <= clip_comb;
		end
	end

	assign result.valid      = valid_s2;
	assign result.sample_out = y_s2;
	assign result.clipped    = clip_s2;

endmodule
